@@ hw/rtl/dnss_pkg.sv @@
package dnss_pkg;

  localparam int unsigned StartBits = 48;
  localparam int unsigned CountBits = 16;
  localparam int unsigned SlotBits  = 5;

  typedef enum logic [1:0] {
    STATUS_ADDED      = 2'd0,
    STATUS_FULL       = 2'd1,
    STATUS_DISPATCHED = 2'd2,
    STATUS_EMPTY      = 2'd3
  } status_t;

  localparam logic KIND_ADD      = 1'b0;
  localparam logic KIND_DISPATCH = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [StartBits-1:0] start_sector;
    logic [CountBits-1:0] sector_count;
  } cmd_t;

  typedef struct packed {
    status_t              status;
    logic [StartBits-1:0] chosen_sector;
    logic [CountBits-1:0] chosen_count;
    logic [SlotBits-1:0]  slot_index;
  } result_t;

endpackage

@@ hw/rtl/dnss_cell.sv @@
// One table slot. On a rotate it takes its left neighbor's entry, so the
// whole table circulates past the comparator at the head of the chain.
module dnss_cell #(
  parameter int unsigned SECTOR_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   shift,
  input  logic                   load,
  input  logic                   load_valid,
  input  logic [SECTOR_BITS-1:0] load_start,
  input  logic [15:0]            load_len,
  input  logic                   prev_valid,
  input  logic [SECTOR_BITS-1:0] prev_start,
  input  logic [15:0]            prev_len,
  output logic                   valid,
  output logic [SECTOR_BITS-1:0] start,
  output logic [15:0]            len
);
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= load_valid;
    end else if (shift) begin
      valid <= prev_valid;
    end
    if (load) begin
      start <= load_start;
      len   <= load_len;
    end else if (shift) begin
      start <= prev_start;
      len   <= prev_len;
    end
  end
endmodule

@@ hw/rtl/directional_nearest_seek_scheduler.sv @@
// Channel  | Ports                  | Handshake
// command  | start, busy, cmd       | accepted when start high and busy low
// result   | done, result           | one-cycle strobe, cannot be stalled
//
// An add rotates the slot chain once, as does a dispatch on an empty table. A dispatch scans
// one rotation, a second one after a direction flip when nothing lies ahead, then rotates
// once more to free the chosen slot. done is high in the first cycle that busy is low again,
// so the next word can be accepted in that same cycle. Reset is synchronous, empties the
// table and parks the head at zero facing forward. The result side never stalls.
module directional_nearest_seek_scheduler #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned SECTOR_BITS = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  dnss_pkg::cmd_t     cmd,
  output logic               busy,
  output logic               done,
  output dnss_pkg::result_t  result
);
  localparam int unsigned IdxBits = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [SECTOR_BITS-1:0] TopSector = '1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ADD   = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_TAKE  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state;
  logic [IdxBits-1:0] pos;       // slot number now at cell 0
  logic               pass2;
  logic               kind;
  logic [SECTOR_BITS-1:0] new_start;
  logic [15:0]        new_len;
  logic [SECTOR_BITS-1:0] head;
  logic               fwd;
  logic               found, any, done_add;
  logic [IdxBits-1:0] best, lowest, free_slot;
  logic [SECTOR_BITS-1:0] best_dist;

  logic                   c_valid [TABLE_DEPTH];
  logic [SECTOR_BITS-1:0] c_start [TABLE_DEPTH];
  logic [15:0]            c_len   [TABLE_DEPTH];
  logic                   shift;
  logic                   w_en, w_valid;
  logic [SECTOR_BITS-1:0] w_start;
  logic [15:0]            w_len;

  assign busy = (state != ST_IDLE);

  // On a shift the entry of cell 0 moves into the last cell, so a write to the slot now at
  // cell 0 is made by loading the last cell instead.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    localparam int unsigned P = (g + 1) % TABLE_DEPTH;
    dnss_cell #(.SECTOR_BITS(SECTOR_BITS)) u_cell (
      .clk, .rst, .shift,
      .load       (w_en && (g == TABLE_DEPTH - 1)),
      .load_valid (w_valid),
      .load_start (w_start),
      .load_len   (w_len),
      .prev_valid (c_valid[P]),
      .prev_start (c_start[P]),
      .prev_len   (c_len[P]),
      .valid      (c_valid[g]),
      .start      (c_start[g]),
      .len        (c_len[g])
    );
  end

  // Comparator on cell 0.
  logic ahead;
  logic [SECTOR_BITS-1:0] gap;
  always_comb begin
    ahead = c_valid[0] && (fwd ? (c_start[0] > head) : (c_start[0] < head));
    gap   = fwd ? (c_start[0] - head) : (head - c_start[0]);
  end

  logic last;
  assign last  = (pos == IdxBits'(TABLE_DEPTH - 1));
  assign shift = (state == ST_ADD) || (state == ST_SCAN) || (state == ST_TAKE);

  always_comb begin
    w_en    = 1'b0;
    w_valid = 1'b0;
    w_start = new_start;
    w_len   = new_len;
    if (state == ST_ADD && !done_add && !c_valid[0]) begin
      w_en = 1'b1; w_valid = 1'b1;
    end
    if (state == ST_TAKE && pos == best) begin
      w_en = 1'b1; w_valid = 1'b0;
      w_start = c_start[0];
      w_len   = c_len[0];
    end
  end

  logic [SECTOR_BITS:0] endsum;
  assign endsum = {1'b0, c_start[0]} + {{(SECTOR_BITS-16+1){1'b0}}, c_len[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      fwd   <= 1'b1;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            kind      <= cmd.kind;
            new_start <= SECTOR_BITS'(cmd.start_sector);
            new_len   <= cmd.sector_count;
            pos <= '0; pass2 <= 1'b0;
            found <= 1'b0; any <= 1'b0; done_add <= 1'b0;
            state <= (cmd.kind == dnss_pkg::KIND_ADD) ? ST_ADD : ST_SCAN;
          end
        end
        ST_ADD: begin
          if (w_en) begin
            done_add <= 1'b1;
            free_slot <= pos;
          end
          pos <= last ? '0 : pos + 1'b1;
          if (last) state <= ST_DONE;
        end
        ST_SCAN: begin
          if (c_valid[0] && !any) begin
            any <= 1'b1; lowest <= pos;
          end
          if (ahead && (!found || gap < best_dist)) begin
            found <= 1'b1; best <= pos; best_dist <= gap;
          end
          pos <= last ? '0 : pos + 1'b1;
          if (last) begin
            if (!(any || c_valid[0])) begin
              state <= ST_DONE;
            end else if (found || ahead) begin
              state <= ST_TAKE;
            end else if (!pass2) begin
              pass2 <= 1'b1; fwd <= !fwd;
            end else begin
              best  <= lowest;
              state <= ST_TAKE;
            end
          end
        end
        ST_TAKE: begin
          if (pos == best) begin
            result.chosen_sector <= dnss_pkg::StartBits'(c_start[0]);
            result.chosen_count  <= c_len[0];
            head <= endsum[SECTOR_BITS] ? TopSector : endsum[SECTOR_BITS-1:0];
          end
          pos <= last ? '0 : pos + 1'b1;
          if (last) state <= ST_DONE;
        end
        ST_DONE: begin
          done  <= 1'b1;
          state <= ST_IDLE;
          if (kind == dnss_pkg::KIND_ADD) begin
            result.status <= done_add ? dnss_pkg::STATUS_ADDED : dnss_pkg::STATUS_FULL;
            result.chosen_sector <= '0;
            result.chosen_count  <= '0;
            result.slot_index <= done_add ? dnss_pkg::SlotBits'(free_slot) : '0;
          end else if (!any) begin
            result.status <= dnss_pkg::STATUS_EMPTY;
            result.chosen_sector <= '0;
            result.chosen_count  <= '0;
            result.slot_index <= '0;
            head <= fwd ? TopSector : '0;
            fwd  <= !fwd;
          end else begin
            result.status <= dnss_pkg::STATUS_DISPATCHED;
            result.slot_index <= dnss_pkg::SlotBits'(best);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

@@ verif/tb_directional_nearest_seek_scheduler.sv @@
module tb_directional_nearest_seek_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import dnss_pkg::*;

  localparam int Depth = 32;
  localparam logic [StartBits-1:0] TopSector = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic busy;
  logic done;
  result_t result;

  directional_nearest_seek_scheduler uut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .result(result)
  );

  always #5 clk = ~clk;

  // Predictor state.
  logic                 pend_valid [Depth];
  logic [StartBits-1:0] pend_start [Depth];
  logic [CountBits-1:0] pend_len [Depth];
  logic [StartBits-1:0] head_pos;
  logic                 head_fwd;

  cmd_t    cmd_words[$];
  result_t expected_words[$];
  int      errors = 0;
  int      occupancy = 0;
  bit      stimulus_done = 0;
  bit      calm = 0;

  function automatic int nearest_in_dir(input logic fwd);
    int best;
    logic [StartBits-1:0] best_dist, d;
    best = -1;
    best_dist = '0;
    for (int i = 0; i < Depth; i++) begin
      if (pend_valid[i]) begin
        if (fwd ? (pend_start[i] > head_pos) : (pend_start[i] < head_pos)) begin
          d = fwd ? pend_start[i] - head_pos : head_pos - pend_start[i];
          if (best < 0 || d < best_dist) begin
            best = i;
            best_dist = d;
          end
        end
      end
    end
    return best;
  endfunction

  function automatic result_t schedule_word(input cmd_t c);
    result_t r;
    int lowest, pick;
    logic [StartBits:0] sum;
    r = '0;
    r.status = STATUS_ADDED;
    if (c.kind == KIND_ADD) begin
      for (int i = 0; i < Depth; i++) begin
        if (!pend_valid[i]) begin
          pend_valid[i] = 1'b1;
          pend_start[i] = c.start_sector;
          pend_len[i] = c.sector_count;
          r.slot_index = i[SlotBits-1:0];
          return r;
        end
      end
      r.status = STATUS_FULL;
      return r;
    end
    lowest = -1;
    for (int i = Depth - 1; i >= 0; i--) if (pend_valid[i]) lowest = i;
    if (lowest < 0) begin
      head_pos = head_fwd ? TopSector : '0;
      head_fwd = ~head_fwd;
      r.status = STATUS_EMPTY;
      return r;
    end
    pick = nearest_in_dir(head_fwd);
    if (pick < 0) begin
      head_fwd = ~head_fwd;
      pick = nearest_in_dir(head_fwd);
      if (pick < 0) pick = lowest;
    end
    pend_valid[pick] = 1'b0;
    sum = {1'b0, pend_start[pick]} + pend_len[pick];
    head_pos = sum[StartBits] ? TopSector : sum[StartBits-1:0];
    r.status = STATUS_DISPATCHED;
    r.chosen_sector = pend_start[pick];
    r.chosen_count = pend_len[pick];
    r.slot_index = pick[SlotBits-1:0];
    return r;
  endfunction

  // Queue-side model of occupancy, used only to steer stimulus.
  task automatic push_word(input logic kind, input logic [StartBits-1:0] s,
                           input logic [CountBits-1:0] n);
    cmd_t c;
    c.kind = kind;
    c.start_sector = s;
    c.sector_count = n;
    cmd_words.push_back(c);
    if (kind == KIND_ADD) begin
      if (occupancy < Depth) occupancy++;
    end else if (occupancy > 0) begin
      occupancy--;
    end
  endtask

  function automatic logic [StartBits-1:0] rand_sector();
    case ($urandom_range(0, 4))
      0: return StartBits'({$urandom, $urandom});
      1: return TopSector - $urandom_range(0, 40);
      2: return StartBits'($urandom_range(0, 40));
      default: return 48'h0000_8000_0000 + $urandom_range(0, 5000);
    endcase
  endfunction

  // Driver: start stays high across back-to-back words.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        void'(cmd_words.pop_front());
      end
      if (cmd_words.size() > 0 && (calm || $urandom_range(0, 99) >= 29)) begin
        cmd <= cmd_words[0];
        start <= 1'b1;
      end else begin
        start <= 1'b0;
        cmd <= {1'($urandom), $urandom, $urandom};
      end
    end
  end

  // Predict at acceptance so results are matched in order.
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      expected_words.push_back(schedule_word(cmd));
    end
  end

  // Monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (result.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, result.status);
          errors++;
        end
        if (result.chosen_sector !== want.chosen_sector) begin
          $error("chosen_sector exp %h got %h", want.chosen_sector, result.chosen_sector);
          errors++;
        end
        if (result.chosen_count !== want.chosen_count) begin
          $error("chosen_count exp %h got %h", want.chosen_count, result.chosen_count);
          errors++;
        end
        if (result.slot_index !== want.slot_index) begin
          $error("slot_index exp %0d got %0d", want.slot_index, result.slot_index);
          errors++;
        end
      end
    end
  end

  initial begin
    int n, burst;
    for (int i = 0; i < Depth; i++) begin
      pend_valid[i] = 1'b0;
      pend_start[i] = '0;
      pend_len[i] = '0;
    end
    head_pos = '0;
    head_fwd = 1'b1;

    // Directed: empty dispatches both ways, extremes, ties, saturation.
    push_word(KIND_DISPATCH, '1, '1);
    push_word(KIND_DISPATCH, '0, '0);
    push_word(KIND_ADD, TopSector, 16'hFFFF);
    push_word(KIND_ADD, '0, '0);
    push_word(KIND_ADD, 48'd100, 16'd5);
    push_word(KIND_ADD, 48'd100, 16'd7);
    push_word(KIND_DISPATCH, '0, '0);
    push_word(KIND_DISPATCH, '0, '0);
    push_word(KIND_DISPATCH, '0, '0);
    push_word(KIND_DISPATCH, '0, '0);
    push_word(KIND_DISPATCH, '0, '0);
    // A zero-length request parks the head at 10, then every pending request sits exactly at it.
    push_word(KIND_ADD, 48'd10, 16'd0);
    push_word(KIND_DISPATCH, '0, '0);
    push_word(KIND_ADD, 48'd10, 16'd3);
    push_word(KIND_ADD, 48'd10, 16'd4);
    push_word(KIND_DISPATCH, '0, '0);
    push_word(KIND_DISPATCH, '0, '0);
    push_word(KIND_DISPATCH, '0, '0);

    // Random phase: bursts that fill toward full, then drain.
    n = 0;
    while (n < 950) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) begin
        if ($urandom_range(0, 99) < ((occupancy < Depth) ? 60 : 20)) begin
          push_word(KIND_ADD, rand_sector(), $urandom_range(0, 3) == 0 ?
                    CountBits'(16'hFFFF - $urandom_range(0, 3)) : CountBits'($urandom));
        end else begin
          push_word(KIND_DISPATCH, rand_sector(), CountBits'($urandom));
        end
        n++;
      end
      burst = $urandom_range(0, 30);
      for (int k = 0; k < burst; k++) begin
        push_word(KIND_DISPATCH, '0, '0);
        n++;
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    fork
      begin
        repeat (20000) @(posedge clk);
        calm = 1;
        repeat (15000) @(posedge clk);
        calm = 0;
      end
    join_none
    wait (cmd_words.size() == 0 && !start);
    wait (expected_words.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb_directional_nearest_seek_scheduler OK");
    end else begin
      $display("tb_directional_nearest_seek_scheduler NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_directional_nearest_seek_scheduler NOT OK");
    $finish;
  end
endmodule
